// ===== hw/rtl/acpr_pkg.sv =====
// Package for the ADC pair requantiser: widths, constants, shared types and the
// per-sample requantise function. No dependencies.
`timescale 1ns / 1ps

package acpr_pkg;

    localparam int RAW_W     = 16;
    localparam int ADC_W     = 12;
    localparam int SMP_W     = 8;
    localparam int OFS_W     = 16;
    localparam int CFG_W     = 11;
    localparam int MAX_PAIRS = 1024;
    localparam int PIDX_W    = $clog2(MAX_PAIRS + 1);
    localparam int CNT_W     = PIDX_W + 1;
    localparam int SUM_W     = CNT_W + SMP_W;
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int DIFF_W    = OFS_W + 2;
    localparam int ROUND     = 16;
    localparam int SHIFT     = 4;
    localparam int Q_MAX     = 127;
    localparam int Q_MIN     = -128;
    localparam int AVG_MAG_MAX = 128;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(96);
    localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(2048);
    localparam logic signed [SMP_W-1:0] MIN_RESET = SMP_W'(Q_MAX);
    localparam logic signed [SMP_W-1:0] MAX_RESET = SMP_W'(Q_MIN);

    typedef struct packed {
        logic load;
        logic skip;
        logic calc;
        logic div_step;
        logic fin;
        logic out_b;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic last;
        logic div_done;
    } t_sts;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_value;
        logic                    out_channel;
        logic                    frame_last;
        logic signed [SMP_W-1:0] frame_min;
        logic signed [SMP_W-1:0] frame_max;
        logic signed [SMP_W-1:0] frame_avg;
        logic signed [OFS_W-1:0] new_offset;
    } t_beat;

    // Invert and mask the raw word, remove the offset, add ROUND, shift right by SHIFT and clamp to a byte.
    function automatic logic signed [SMP_W-1:0] requant(
        input logic [RAW_W-1:0]        raw,
        input logic signed [OFS_W-1:0] ofs
    );
        logic [DIFF_W-1:0]                vx;
        logic signed [DIFF_W-1:0]         d;
        logic signed [DIFF_W-SHIFT-1:0]   q;
        logic signed [SMP_W-1:0]          res;
        vx = {{(DIFF_W-ADC_W){1'b0}}, ~raw[ADC_W-1:0]};
        d  = $signed(vx) - DIFF_W'(ofs) + DIFF_W'(ROUND);
        q  = $signed(d[DIFF_W-1:SHIFT]);
        if (q > Q_MAX) begin
            res = SMP_W'(Q_MAX);
        end else if (q < Q_MIN) begin
            res = SMP_W'(Q_MIN);
        end else begin
            res = q[SMP_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/acpr_if.sv =====
// Channel interfaces for the ADC pair requantiser: raw pair input and sample output.
// Depends on acpr_pkg.
`timescale 1ns / 1ps

interface acpr_pair_if import acpr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             channel;
    logic [RAW_W-1:0] raw_first;
    logic [RAW_W-1:0] raw_second;

    modport source (output valid, channel, raw_first, raw_second, input ready);
    modport sink   (input valid, channel, raw_first, raw_second, output ready);
endinterface

interface acpr_smp_if import acpr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_value;
    logic                    out_channel;
    logic                    frame_last;
    logic signed [SMP_W-1:0] frame_min;
    logic signed [SMP_W-1:0] frame_max;
    logic signed [SMP_W-1:0] frame_avg;
    logic signed [OFS_W-1:0] new_offset;

    modport source (output valid, sample_value, out_channel, frame_last, frame_min,
                    frame_max, frame_avg, new_offset, input ready);
    modport sink   (input valid, sample_value, out_channel, frame_last, frame_min,
                    frame_max, frame_avg, new_offset, output ready);
endinterface

// ===== hw/rtl/acpr_ctrl.sv =====
// Controller state machine of the ADC pair requantiser.
// Depends on acpr_pkg; drives the handshakes and the datapath commands.
`timescale 1ns / 1ps

module acpr_ctrl import acpr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CALC  = 6'b000010,
        S_DIV   = 6'b000100,
        S_FIN   = 6'b001000,
        S_OUT_A = 6'b010000,
        S_OUT_B = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.first) begin
                        o_cmd.skip = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CALC;
                    end
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_sts.last ? S_DIV : S_OUT_A;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT_A;
            end
            S_OUT_A: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_OUT_B;
                end
            end
            S_OUT_B: begin
                o_out_valid = 1'b1;
                o_cmd.out_b = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while an output beat is pending");

endmodule

// ===== hw/rtl/acpr_dpath.sv =====
// Datapath of the ADC pair requantiser: offsets, frame statistics, the
// bit-serial average divider and the output beat registers. Depends on acpr_pkg.
`timescale 1ns / 1ps

module acpr_dpath import acpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_channel,
    input  logic [RAW_W-1:0] i_raw_first,
    input  logic [RAW_W-1:0] i_raw_second,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output t_beat            o_beat
);

    logic [CFG_W-1:0]        r_cfg;
    logic [OFS_W-1:0]        r_ofs [2];
    logic signed [SMP_W-1:0] r_run_min;
    logic signed [SMP_W-1:0] r_run_max;
    logic signed [SUM_W-1:0] r_run_sum;
    logic [PIDX_W-1:0]       r_pair_idx;

    logic                    r_ch;
    logic [RAW_W-1:0]        r_raw0;
    logic [RAW_W-1:0]        r_raw1;
    logic signed [SMP_W-1:0] r_s0;
    logic signed [SMP_W-1:0] r_s1;
    logic                    r_last;

    logic [SUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_dvs;
    logic                    r_neg;
    logic [DCNT_W-1:0]       r_dcnt;

    logic signed [SMP_W-1:0] r_frm_min;
    logic signed [SMP_W-1:0] r_frm_max;
    logic signed [SMP_W-1:0] r_frm_avg;
    logic signed [OFS_W-1:0] r_frm_ofs;

    logic [PIDX_W-1:0]       limit;
    logic signed [SMP_W-1:0] v0;
    logic signed [SMP_W-1:0] v1;
    logic signed [SMP_W-1:0] min_new;
    logic signed [SMP_W-1:0] max_new;
    logic signed [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0]        sum_mag;
    logic [CNT_W:0]          rem_sh;
    logic [CNT_W:0]          rem_diff;
    logic                    qbit;
    logic [SUM_W-1:0]        avg_full;
    logic signed [SMP_W-1:0] avg;
    logic [OFS_W-1:0]        ofs_new;

    always_comb begin
        if (r_cfg == '0) begin
            limit = PIDX_W'(1);
        end else if (32'(r_cfg) > MAX_PAIRS) begin
            limit = PIDX_W'(MAX_PAIRS);
        end else begin
            limit = PIDX_W'(r_cfg);
        end
    end

    assign o_sts.first    = (r_pair_idx == '0);
    assign o_sts.last     = (r_pair_idx >= limit);
    assign o_sts.div_done = (r_dcnt == DCNT_W'(DIV_STEPS - 1));

    always_comb begin
        v0 = requant(r_raw0, $signed(r_ofs[r_ch]));
        v1 = requant(r_raw1, $signed(r_ofs[r_ch]));
        min_new = r_run_min;
        if (v0 < min_new) begin
            min_new = v0;
        end
        if (v1 < min_new) begin
            min_new = v1;
        end
        max_new = r_run_max;
        if (v0 > max_new) begin
            max_new = v0;
        end
        if (v1 > max_new) begin
            max_new = v1;
        end
        sum_new = r_run_sum + SUM_W'(v0) + SUM_W'(v1);
        sum_mag = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
    end

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign qbit     = ~rem_diff[CNT_W];

    assign avg_full = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign avg      = $signed(avg_full[SMP_W-1:0]);
    assign ofs_new  = r_ofs[r_ch]
                    + {{(OFS_W-SMP_W-SHIFT){avg[SMP_W-1]}}, avg, {SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_ofs[0]   <= OFS_RESET;
            r_ofs[1]   <= OFS_RESET;
            r_run_min  <= MIN_RESET;
            r_run_max  <= MAX_RESET;
            r_run_sum  <= '0;
            r_pair_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.skip) begin
                r_pair_idx <= PIDX_W'(1);
            end
            if (i_cmd.calc) begin
                r_run_min <= min_new;
                r_run_max <= max_new;
                r_run_sum <= sum_new;
                if (!o_sts.last) begin
                    r_pair_idx <= r_pair_idx + 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_ofs[r_ch] <= ofs_new;
                r_run_min   <= MIN_RESET;
                r_run_max   <= MAX_RESET;
                r_run_sum   <= '0;
                r_pair_idx  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= i_channel;
            r_raw0 <= i_raw_first;
            r_raw1 <= i_raw_second;
        end
        if (i_cmd.calc) begin
            r_s0   <= v0;
            r_s1   <= v1;
            r_last <= o_sts.last;
            r_quo  <= sum_mag;
            r_neg  <= sum_new[SUM_W-1];
            r_rem  <= '0;
            r_dvs  <= {r_pair_idx, 1'b0};
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SUM_W-2:0], qbit};
            r_rem  <= qbit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.fin) begin
            r_frm_min <= r_run_min;
            r_frm_max <= r_run_max;
            r_frm_avg <= avg;
            r_frm_ofs <= $signed(ofs_new);
        end
    end

    always_comb begin
        o_beat             = '0;
        o_beat.out_channel = r_ch;
        if (i_cmd.out_b) begin
            o_beat.sample_value = r_s0;
            if (r_last) begin
                o_beat.frame_last = 1'b1;
                o_beat.frame_min  = r_frm_min;
                o_beat.frame_max  = r_frm_max;
                o_beat.frame_avg  = r_frm_avg;
                o_beat.new_offset = r_frm_ofs;
            end
        end else begin
            o_beat.sample_value = r_s1;
        end
    end

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_pair_idx == '0) && (r_run_sum == '0))
        else $error("frame end did not clear the statistics");

    a_avg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (r_quo <= SUM_W'(AVG_MAG_MAX)))
        else $error("average magnitude exceeds a byte");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pair_idx >= PIDX_W'(2)) |-> (r_run_min <= r_run_max))
        else $error("running minimum above running maximum");

endmodule

// ===== hw/rtl/adc_pair_requantizer_offset_tracking.sv =====
// Top level of the ADC pair requantiser with per-channel offset tracking.
// Depends on acpr_pkg, acpr_if, acpr_ctrl and acpr_dpath.
// The block takes one raw pair per input beat and gives two sample beats per kept
// pair, second sample first; the first pair of each frame is dropped. A kept pair
// goes through accept, requantise and update statistics, then one state per output
// beat, each held until the sink is ready. The last pair of a frame adds the
// one-bit-per-cycle average divider and a step that applies the offset correction.
// The frame length register may be written only while idle.
`timescale 1ns / 1ps

module adc_pair_requantizer_offset_tracking import acpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    acpr_pair_if.sink        i_pair,
    acpr_smp_if.source       o_smp
);

    t_cmd  cmd;
    t_sts  sts;
    t_beat beat;
    logic  in_ready;
    logic  out_valid;

    acpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pair.valid),
        .i_out_ready (o_smp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    acpr_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_channel    (i_pair.channel),
        .i_raw_first  (i_pair.raw_first),
        .i_raw_second (i_pair.raw_second),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_beat       (beat)
    );

    assign i_pair.ready       = in_ready;
    assign o_smp.valid        = out_valid;
    assign o_smp.sample_value = beat.sample_value;
    assign o_smp.out_channel  = beat.out_channel;
    assign o_smp.frame_last   = beat.frame_last;
    assign o_smp.frame_min    = beat.frame_min;
    assign o_smp.frame_max    = beat.frame_max;
    assign o_smp.frame_avg    = beat.frame_avg;
    assign o_smp.new_offset   = beat.new_offset;

endmodule
